>>> rtl/core/sfla_pkg.sv
// Shared types, constants and codes for the segregated free list allocator.
package sfla_pkg;

  localparam int SIZE_CLASSES  = 20;
  localparam int CLASS_DEPTH   = 64;
  localparam int LARGE_DEPTH   = 32;
  localparam int ADDR_BITS     = 24;

  localparam int FIELD_W       = 24;
  localparam int SMALL_CLASSES = SIZE_CLASSES - 1;
  localparam int STORE_DEPTH   = SMALL_CLASSES * CLASS_DEPTH;
  localparam int STORE_AW      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CLASS_IDX_W   = (SMALL_CLASSES > 1) ? $clog2(SMALL_CLASSES) : 1;
  localparam int CLASS_CNT_W   = $clog2(CLASS_DEPTH + 1);
  localparam int LARGE_IDX_W   = (LARGE_DEPTH > 1) ? $clog2(LARGE_DEPTH) : 1;
  localparam int LARGE_CNT_W   = $clog2(LARGE_DEPTH + 1);

  localparam logic [FIELD_W-1:0] ADDR_MASK =
    (ADDR_BITS >= FIELD_W) ? {FIELD_W{1'b1}} : FIELD_W'((64'd1 << ADDR_BITS) - 64'd1);

  localparam logic [FIELD_W-1:0] HEAP_BASE_RESET  = '0;
  localparam logic [FIELD_W-1:0] HEAP_WORDS_RESET = FIELD_W'(4096);

  typedef enum logic [0:0] {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_OOM     = 2'd1,
    STATUS_DROPPED = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    REG_HEAP_BASE  = 1'b0,
    REG_HEAP_WORDS = 1'b1
  } cfg_index_t;

  typedef struct packed {
    func_t              func;
    logic [FIELD_W-1:0] size_words;
    logic [FIELD_W-1:0] block_address;
  } cmd_t;

  typedef struct packed {
    logic [FIELD_W-1:0] alloc_address;
    status_t            status;
    logic               reused;
  } result_t;

  typedef struct packed {
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
    logic [FIELD_W-1:0] limit;
  } unit_in_t;

  typedef struct packed {
    logic [FIELD_W:0] sum;
    logic             reach;
    logic             equal;
  } unit_out_t;

endpackage

>>> rtl/core/sfla_ram.sv
// Generic single write port RAM with one registered read port.
module sfla_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1216,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/sfla_unit.sv
// Shared adder and comparator used by the search and bump steps of the allocator sequencer.
module sfla_unit import sfla_pkg::*; (
  input  unit_in_t  op,
  output unit_out_t res
);

  logic [FIELD_W:0] sum;

  assign sum       = {1'b0, op.a} + {1'b0, op.b};
  assign res.sum   = sum;
  assign res.reach = (sum >= {1'b0, op.limit});
  assign res.equal = (op.a == op.b);

endmodule

>>> rtl/core/segregated_free_list_allocator_top.sv
// Allocator top level: a free completes in the dispatch state, a small pop passes through
// dispatch and pop. A large allocate compares one list entry per cycle, newest first, and
// falls back to a bump allocation (check, then address) when no entry matches in size.
// One transaction is in flight at a time; busy is low again in the cycle done is high.
// Synchronous reset empties the stacks and the large list, zeroes the bump pointer and
// returns heap_base and heap_words to their defaults. Every result is presented for one
// cycle with done; the receiver cannot stall it.
module segregated_free_list_allocator_top import sfla_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  cmd_t               cmd,
  output logic               done,
  output result_t            result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  cfg_index_t         cfg_index,
  input  logic [FIELD_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP,
    S_SEARCH,
    S_BUMP_CHECK,
    S_BUMP_ADDR
  } state_t;

  state_t                  state;
  logic [FIELD_W-1:0]      heap_base;
  logic [FIELD_W-1:0]      heap_words;
  logic [FIELD_W-1:0]      bump_offset;
  logic [FIELD_W-1:0]      bump_sum;
  func_t                   op_func;
  logic [FIELD_W-1:0]      op_size;
  logic [FIELD_W-1:0]      op_addr;
  logic [CLASS_CNT_W-1:0]  class_count [SMALL_CLASSES];
  logic [FIELD_W-1:0]      large_addr [LARGE_DEPTH];
  logic [FIELD_W-1:0]      large_size [LARGE_DEPTH];
  logic [LARGE_CNT_W-1:0]  large_count;
  logic [LARGE_IDX_W-1:0]  search_idx;

  logic                    is_small;
  logic [CLASS_IDX_W-1:0]  cls;
  logic [CLASS_CNT_W-1:0]  cls_count;
  logic [STORE_AW-1:0]     store_base;
  logic                    class_full;
  logic                    large_full;
  logic                    store_we;
  logic [STORE_AW-1:0]     store_waddr;
  logic [STORE_AW-1:0]     store_raddr;
  logic [FIELD_W-1:0]      store_rdata;
  unit_in_t                unit_op;
  unit_out_t               unit_res;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign is_small    = (op_size != '0) && (op_size < FIELD_W'(SIZE_CLASSES));
  assign cls         = CLASS_IDX_W'(op_size - FIELD_W'(1));
  assign cls_count   = class_count[cls];
  assign store_base  = STORE_AW'(cls) * STORE_AW'(CLASS_DEPTH);
  assign class_full  = (cls_count >= CLASS_CNT_W'(CLASS_DEPTH));
  assign large_full  = (large_count >= LARGE_CNT_W'(LARGE_DEPTH));
  assign store_waddr = store_base + STORE_AW'(cls_count);
  assign store_raddr = store_base + STORE_AW'(cls_count - CLASS_CNT_W'(1));
  assign store_we    = (state == S_DISPATCH) && (op_func == FUNC_FREE) && is_small
                       && !class_full;

  always_comb begin
    unit_op = '0;
    unique case (state)
      S_SEARCH: begin
        unit_op.a = op_size;
        unit_op.b = large_size[search_idx];
      end
      S_BUMP_CHECK: begin
        unit_op.a     = bump_offset;
        unit_op.b     = op_size;
        unit_op.limit = heap_words;
      end
      S_BUMP_ADDR: begin
        unit_op.a = heap_base;
        unit_op.b = bump_offset;
      end
      S_IDLE, S_DISPATCH, S_POP: begin
        unit_op = '0;
      end
      default: begin
        unit_op = '0;
      end
    endcase
  end

  sfla_unit u_unit (
    .op  (unit_op),
    .res (unit_res)
  );

  sfla_ram #(
    .WIDTH (FIELD_W),
    .DEPTH (STORE_DEPTH)
  ) u_class_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (op_addr),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      heap_base   <= HEAP_BASE_RESET;
      heap_words  <= HEAP_WORDS_RESET;
      bump_offset <= '0;
      large_count <= '0;
      for (int k = 0; k < SMALL_CLASSES; k++) begin
        class_count[CLASS_IDX_W'(k)] <= '0;
      end
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_HEAP_BASE:  heap_base  <= cfg_data;
          REG_HEAP_WORDS: heap_words <= cfg_data;
          default:        heap_base  <= heap_base;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_func <= cmd.func;
            op_size <= cmd.size_words;
            op_addr <= cmd.block_address & ADDR_MASK;
            state   <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          if (op_func == FUNC_FREE) begin
            done                 <= 1'b1;
            result.alloc_address <= '0;
            result.reused        <= 1'b0;
            state                <= S_IDLE;
            if (is_small) begin
              if (class_full) begin
                result.status <= STATUS_DROPPED;
              end else begin
                result.status    <= STATUS_OK;
                class_count[cls] <= cls_count + CLASS_CNT_W'(1);
              end
            end else begin
              if (large_full) begin
                result.status <= STATUS_DROPPED;
              end else begin
                result.status                              <= STATUS_OK;
                large_addr[LARGE_IDX_W'(large_count)]      <= op_addr;
                large_size[LARGE_IDX_W'(large_count)]      <= op_size;
                large_count                                <= large_count + LARGE_CNT_W'(1);
              end
            end
          end else if (is_small) begin
            if (cls_count != '0) begin
              class_count[cls] <= cls_count - CLASS_CNT_W'(1);
              state            <= S_POP;
            end else begin
              state <= S_BUMP_CHECK;
            end
          end else if (large_count != '0) begin
            search_idx <= LARGE_IDX_W'(large_count - LARGE_CNT_W'(1));
            state      <= S_SEARCH;
          end else begin
            state <= S_BUMP_CHECK;
          end
        end
        S_POP: begin
          done                 <= 1'b1;
          result.alloc_address <= store_rdata;
          result.status        <= STATUS_OK;
          result.reused        <= 1'b1;
          state                <= S_IDLE;
        end
        S_SEARCH: begin
          if (unit_res.equal) begin
            done                 <= 1'b1;
            result.alloc_address <= large_addr[search_idx];
            result.status        <= STATUS_OK;
            result.reused        <= 1'b1;
            large_count          <= large_count - LARGE_CNT_W'(1);
            for (int j = 0; j < LARGE_DEPTH - 1; j++) begin
              if (LARGE_IDX_W'(j) >= search_idx) begin
                large_addr[LARGE_IDX_W'(j)] <= large_addr[LARGE_IDX_W'(j + 1)];
                large_size[LARGE_IDX_W'(j)] <= large_size[LARGE_IDX_W'(j + 1)];
              end
            end
            state <= S_IDLE;
          end else if (search_idx == '0) begin
            state <= S_BUMP_CHECK;
          end else begin
            search_idx <= search_idx - LARGE_IDX_W'(1);
          end
        end
        S_BUMP_CHECK: begin
          if (unit_res.reach) begin
            done                 <= 1'b1;
            result.alloc_address <= '0;
            result.status        <= STATUS_OOM;
            result.reused        <= 1'b0;
            state                <= S_IDLE;
          end else begin
            bump_sum <= unit_res.sum[FIELD_W-1:0];
            state    <= S_BUMP_ADDR;
          end
        end
        S_BUMP_ADDR: begin
          done                 <= 1'b1;
          result.alloc_address <= unit_res.sum[FIELD_W-1:0] & ADDR_MASK;
          result.status        <= STATUS_OK;
          result.reused        <= 1'b0;
          bump_offset          <= bump_sum;
          state                <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
